### rtl/ssr_pkg.sv
// Shared types and constants for the stream search-and-replace block.
package ssr_pkg;

	// Window and replacement sizes.
	localparam int MAX_PATTERN     = 8;
	localparam int MAX_REPLACEMENT = 8;
	localparam int WIN_IDX_W       = $clog2(MAX_PATTERN);
	localparam int LEN_W           = 4;
	localparam int LIMIT_W         = 16;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES      = 3'd0,
		REG_PATTERN_LENGTH     = 3'd1,
		REG_REPLACEMENT_BYTES  = 3'd2,
		REG_REPLACEMENT_LENGTH = 3'd3,
		REG_BUFFER_LIMIT       = 3'd4
	} cfg_reg_t;

	// Input beat.
	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_beat_t;

	// Output beat.
	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic       out_last;
		logic       overflow;
	} out_beat_t;

	// Work for the back end: an ordered list of characters to emit.
	typedef struct packed {
		logic [MAX_PATTERN-1:0][7:0] chars;
		logic [LEN_W-1:0]            count;
		logic                        last;
	} cmd_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

### rtl/stream_search_replace.sv
// Top level of the stream search-and-replace block.
// One character enters per beat and the block sustains one character per clock while the text
// passes through unchanged and the output is not stalled. Every accepted beat gives the back
// end one command, and the back end emits at most one output beat per clock. A beat that
// completes a match emits the replacement characters, or none when the replacement is empty.
// The final beat of a text emits every character still held in the window (at most eight).
// Characters that fall past the output limit are dropped. A four-entry command queue between
// the front end and the back end absorbs these bursts, so input is stalled only once the queue
// is full. Output is limited to buffer_limit minus one characters per text; later characters
// are dropped and the overflow flag rides on the final beat.
module stream_search_replace (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  ssr_pkg::in_beat_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output ssr_pkg::out_beat_t                 out_data,
	input  logic                               cfg_wr_en,
	input  logic [ssr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [ssr_pkg::CFG_DATA_W-1:0] pattern_bytes_q;
	logic [ssr_pkg::LEN_W-1:0]      pattern_length_q;
	logic [ssr_pkg::CFG_DATA_W-1:0] replacement_bytes_q;
	logic [ssr_pkg::LEN_W-1:0]      replacement_length_q;
	logic [ssr_pkg::LIMIT_W-1:0]    buffer_limit_q;

	logic [ssr_pkg::LEN_W-1:0] plen;
	logic [ssr_pkg::LEN_W-1:0] rlen;
	logic                      push;
	logic                      pop;
	ssr_pkg::cmd_t             push_cmd;
	ssr_pkg::cmd_t             head;
	ssr_pkg::q_status_t        q_status;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= '0;
			pattern_length_q     <= '0;
			replacement_bytes_q  <= '0;
			replacement_length_q <= '0;
			buffer_limit_q       <= '1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ssr_pkg::REG_PATTERN_BYTES:      pattern_bytes_q <= cfg_data;
				ssr_pkg::REG_PATTERN_LENGTH:     pattern_length_q <= cfg_data[ssr_pkg::LEN_W-1:0];
				ssr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes_q <= cfg_data;
				ssr_pkg::REG_REPLACEMENT_LENGTH: begin
					replacement_length_q <= cfg_data[ssr_pkg::LEN_W-1:0];
				end
				ssr_pkg::REG_BUFFER_LIMIT:       buffer_limit_q <= cfg_data[ssr_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Lengths saturate at the window and replacement sizes.
	assign plen = (pattern_length_q > ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN)) ?
		ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN) : pattern_length_q;
	assign rlen = (replacement_length_q > ssr_pkg::LEN_W'(ssr_pkg::MAX_REPLACEMENT)) ?
		ssr_pkg::LEN_W'(ssr_pkg::MAX_REPLACEMENT) : replacement_length_q;

	ssr_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.in_data           (in_data),
		.pattern_bytes     (pattern_bytes_q),
		.plen              (plen),
		.replacement_bytes (replacement_bytes_q),
		.rlen              (rlen),
		.q_status          (q_status),
		.push              (push),
		.push_cmd          (push_cmd)
	);

	ssr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	ssr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.buffer_limit (buffer_limit_q),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data)
	);

	// An empty-character beat is only ever the final beat of a text.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.has_char) |-> out_data.out_last)
		else $error("empty beat without out_last");

	// Overflow is reported on the final beat alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.overflow) |-> out_data.out_last)
		else $error("overflow flagged on a non-final beat");

	// The back end never pops an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty command queue");

	// Input is held off only while the queue is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_status.empty |-> !in_stall)
		else $error("input stalled with an empty queue");

endmodule

### rtl/ssr_front.sv
// Front end: accepts characters, keeps the match window and builds emit commands.
module ssr_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  ssr_pkg::in_beat_t                     in_data,
	input  logic [ssr_pkg::CFG_DATA_W-1:0]        pattern_bytes,
	input  logic [ssr_pkg::LEN_W-1:0]             plen,
	input  logic [ssr_pkg::CFG_DATA_W-1:0]        replacement_bytes,
	input  logic [ssr_pkg::LEN_W-1:0]             rlen,
	input  ssr_pkg::q_status_t                    q_status,
	output logic                                  push,
	output ssr_pkg::cmd_t                         push_cmd
);

	logic [ssr_pkg::MAX_PATTERN-1:0][7:0] window_q;
	logic [ssr_pkg::LEN_W-1:0]            wc_q;
	logic [ssr_pkg::MAX_PATTERN-1:0][7:0] win_new;
	logic [ssr_pkg::MAX_PATTERN-1:0][7:0] win_shift;
	logic [ssr_pkg::LEN_W-1:0]            wc_inc;
	logic                                 match;
	logic                                 do_pop;

	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;
	assign wc_inc   = wc_q + 1'b1;
	assign do_pop   = (wc_inc >= plen);

	// Window with the new character placed, its shifted form, and the compare.
	always_comb begin
		win_new = window_q;
		win_new[wc_q[ssr_pkg::WIN_IDX_W-1:0]] = in_data.in_char;
		win_shift = win_new >> 8;
		match = (wc_inc == plen) && (plen != '0);
		for (int i = 0; i < ssr_pkg::MAX_PATTERN; i++) begin
			if ((ssr_pkg::LEN_W'(i) < plen) && (win_new[i] != pattern_bytes[8*i +: 8])) begin
				match = 1'b0;
			end
		end
	end

	// Command: replacement on a match, whole window on the final beat, else the oldest or nothing.
	always_comb begin
		push_cmd.last = in_data.in_last;
		if (match) begin
			push_cmd.chars = replacement_bytes;
			push_cmd.count = rlen;
		end else if (in_data.in_last) begin
			push_cmd.chars = win_new;
			push_cmd.count = wc_inc;
		end else if (do_pop) begin
			push_cmd.chars = win_new;
			push_cmd.count = ssr_pkg::LEN_W'(1);
		end else begin
			push_cmd.chars = win_new;
			push_cmd.count = '0;
		end
	end

	// Window storage needs no reset; only written entries are read.
	always_ff @(posedge clk) begin
		if (push) begin
			window_q <= do_pop ? win_shift : win_new;
		end
	end

	// Window fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= '0;
		end else if (push) begin
			if (match || in_data.in_last) begin
				wc_q <= '0;
			end else if (!do_pop) begin
				wc_q <= wc_inc;
			end
		end
	end

endmodule

### rtl/ssr_queue.sv
// Small command queue that decouples the front end from the back end.
module ssr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ssr_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output ssr_pkg::cmd_t      head,
	output ssr_pkg::q_status_t status
);

	ssr_pkg::cmd_t                   slots_q [ssr_pkg::QUEUE_DEPTH];
	logic [ssr_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [ssr_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [ssr_pkg::QUEUE_PTR_W:0]   fill_q;

	assign head         = slots_q[rd_ptr_q];
	assign status.full  = (fill_q == (ssr_pkg::QUEUE_PTR_W+1)'(ssr_pkg::QUEUE_DEPTH));
	assign status.empty = (fill_q == '0);

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### rtl/ssr_back.sv
// Back end: expands commands into output beats and enforces the output limit.
module ssr_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ssr_pkg::cmd_t                   head,
	input  ssr_pkg::q_status_t              q_status,
	input  logic [ssr_pkg::LIMIT_W-1:0]     buffer_limit,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ssr_pkg::out_beat_t              out_data
);

	logic [ssr_pkg::WIN_IDX_W-1:0] cursor_q;
	logic [ssr_pkg::LIMIT_W-1:0]   emitted_q;
	logic                          overflowed_q;
	logic                          out_valid_q;
	ssr_pkg::out_beat_t            out_data_q;

	logic               fire;
	logic               room;
	logic               has_byte;
	logic               is_tail;
	logic               next_room;
	logic               beat;
	logic               done;
	logic               final_beat;
	ssr_pkg::out_beat_t beat_data;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign fire      = !q_status.empty && (!out_valid_q || !out_stall);
	assign pop       = fire && done;

	// Limit checks for this character and the one after it.
	assign room      = ({1'b0, emitted_q} + 17'd1) < {1'b0, buffer_limit};
	assign next_room = ({1'b0, emitted_q} + 17'd2) < {1'b0, buffer_limit};
	assign has_byte  = {1'b0, cursor_q} < head.count;
	assign is_tail   = ({1'b0, cursor_q} + 1'b1) == head.count;

	// Decide this cycle's beat; once the limit is hit every later character drops.
	always_comb begin
		beat       = 1'b0;
		done       = 1'b1;
		final_beat = 1'b0;
		beat_data  = '0;
		if (has_byte && room) begin
			final_beat         = head.last && (is_tail || !next_room);
			beat               = 1'b1;
			done               = is_tail || final_beat;
			beat_data.out_char = head.chars[cursor_q];
			beat_data.has_char = 1'b1;
			beat_data.out_last = final_beat;
			beat_data.overflow = final_beat && (overflowed_q || !is_tail);
		end else if (head.last) begin
			final_beat         = 1'b1;
			beat               = 1'b1;
			beat_data.out_last = 1'b1;
			beat_data.overflow = overflowed_q || has_byte || (buffer_limit == '0);
		end
	end

	// Cursor, output counters and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q     <= '0;
			emitted_q    <= '0;
			overflowed_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				cursor_q <= done ? '0 : cursor_q + 1'b1;
				if (beat) begin
					out_valid_q <= 1'b1;
				end
				if (final_beat) begin
					emitted_q    <= '0;
					overflowed_q <= 1'b0;
				end else if (beat) begin
					emitted_q <= emitted_q + 1'b1;
				end else if (has_byte) begin
					overflowed_q <= 1'b1;
				end
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (fire && beat) begin
			out_data_q <= beat_data;
		end
	end

endmodule
